@@ sv/huffman_tree_builder_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Huffman tree builder assertion macros
// Concurrent assertion wrappers, removable with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_BUILDER_UNIT_ASSERT_SVH
`define HUFFMAN_TREE_BUILDER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HTB_ASSERT_CLK(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("huffman tree builder assertion failed");
`define HTB_ASSERT(lbl, prop) `HTB_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define HTB_ASSERT_CLK(lbl, ck, rn, prop)
`define HTB_ASSERT(lbl, prop)
`endif
`endif

@@ sv/htb_pkg.sv @@
// ----------------------------------------------------------------------------
// Huffman tree builder package
// Shared codes, defaults and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package htb_pkg;
  localparam int SYMBOLS_DEF    = 256;
  localparam int COUNT_BITS_DEF = 32;
  localparam int ID_W           = 9;
  localparam int IN_CNT_W       = 32;
  localparam int OUT_CNT_W      = 32;
  localparam int IN_DATA_W      = 40;
  localparam int OUT_DATA_W     = 64;

  localparam logic [ID_W-1:0] ID_FIRST_INT = 9'd256;
  localparam logic [ID_W-1:0] ID_LAST      = 9'd511;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_MERGE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] KIND_MERGE = 2'd0;
  localparam logic [1:0] KIND_ROOT  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic ld;    // insert input leaf
    logic clr;   // empty list
    logic eval;  // take front entries, form result
    logic ins;   // insert merged node
  } htb_cmd_t;

  typedef struct packed {
    logic two_plus;  // at least two entries
  } htb_sts_t;
endpackage
`default_nettype wire

@@ sv/htb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Huffman tree builder controller
// Sequences load, clear and merge items and holds the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module htb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [1:0]        in_action,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire htb_pkg::htb_sts_t sts,
  output htb_pkg::htb_cmd_t      cmd
);
  import htb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_INS  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign acc        = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_action)
            ACT_LOAD:  cmd.ld = 1'b1;
            ACT_CLEAR: cmd.clr = 1'b1;
            ACT_MERGE: state_nxt = ST_EVAL;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.two_plus ? ST_INS : ST_OUT;
      end
      ST_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

@@ sv/htb_dp.sv @@
// ----------------------------------------------------------------------------
// Huffman tree builder datapath
// Sorted register list with parallel insert, pop of two, and result regs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "huffman_tree_builder_unit_assert.svh"
module htb_dp #(
  parameter int SYMBOLS    = htb_pkg::SYMBOLS_DEF,
  parameter int COUNT_BITS = htb_pkg::COUNT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire htb_pkg::htb_cmd_t            cmd,
  output htb_pkg::htb_sts_t                 sts,
  input  wire logic [7:0]                   in_symbol,
  input  wire logic [htb_pkg::IN_CNT_W-1:0] in_count,
  output logic [1:0]                        res_kind,
  output logic [htb_pkg::ID_W-1:0]          res_first,
  output logic [htb_pkg::ID_W-1:0]          res_second,
  output logic [htb_pkg::ID_W-1:0]          res_node,
  output logic [htb_pkg::OUT_CNT_W-1:0]     res_count
);
  import htb_pkg::*;

  localparam int CW = COUNT_BITS;
  localparam int TW = $clog2(SYMBOLS + 1);

  logic [ID_W-1:0] id_r  [SYMBOLS];
  logic [CW-1:0]   cnt_r [SYMBOLS];
  logic [TW-1:0]   total_r, total_nxt;
  logic [ID_W-1:0] next_id_r, next_id_nxt;
  logic [1:0]      kind_r;
  logic [ID_W-1:0] first_r, second_r, node_r;
  logic [CW-1:0]   sum_r;

  logic [CW-1:0]   ld_cnt;
  logic            ld_ok;
  logic            ins_en;
  logic [ID_W-1:0] ins_id;
  logic [CW-1:0]   ins_cnt;
  logic [SYMBOLS-1:0] gt;
  logic [CW:0]     sum_w;
  logic [CW-1:0]   sum_sat;

  assign ld_cnt  = CW'(in_count);
  assign ld_ok   = (ld_cnt != '0) && ({1'b0, in_symbol} < ID_W'(SYMBOLS))
                   && (total_r < TW'(SYMBOLS));
  assign ins_en  = (cmd.ld && ld_ok) || cmd.ins;
  assign ins_id  = cmd.ins ? node_r : {1'b0, in_symbol};
  assign ins_cnt = cmd.ins ? sum_r : ld_cnt;
  assign sts.two_plus = (total_r >= TW'(2));

  assign sum_w   = {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
  assign sum_sat = sum_w[CW] ? '1 : sum_w[CW-1:0];

  genvar k;
  generate
    for (k = 0; k < SYMBOLS; k++) begin : g_cell
      assign gt[k] = (TW'(k) < total_r) && (ins_cnt > cnt_r[k]);
      always_ff @(posedge clk) begin
        if (ins_en) begin
          if (!gt[k]) begin
            if (k == 0) begin
              id_r[k]  <= ins_id;
              cnt_r[k] <= ins_cnt;
            end else if (gt[(k == 0) ? 0 : k-1]) begin
              id_r[k]  <= ins_id;
              cnt_r[k] <= ins_cnt;
            end else begin
              id_r[k]  <= id_r[(k == 0) ? 0 : k-1];
              cnt_r[k] <= cnt_r[(k == 0) ? 0 : k-1];
            end
          end
        end else if (cmd.eval && sts.two_plus && (k + 2 < SYMBOLS)) begin
          id_r[k]  <= id_r[(k + 2 < SYMBOLS) ? k+2 : k];
          cnt_r[k] <= cnt_r[(k + 2 < SYMBOLS) ? k+2 : k];
        end
      end
    end
  endgenerate

  always_comb begin
    total_nxt   = total_r;
    next_id_nxt = next_id_r;
    if (cmd.clr) begin
      total_nxt   = '0;
      next_id_nxt = ID_FIRST_INT;
    end else if (cmd.ld && ld_ok) begin
      total_nxt = total_r + TW'(1);
    end else if (cmd.eval && sts.two_plus) begin
      total_nxt = total_r - TW'(2);
    end else if (cmd.ins) begin
      total_nxt = total_r + TW'(1);
      if (next_id_r < ID_LAST) next_id_nxt = next_id_r + ID_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      next_id_r <= ID_FIRST_INT;
    end else begin
      total_r   <= total_nxt;
      next_id_r <= next_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      if (total_r == '0) begin
        kind_r   <= KIND_EMPTY;
        first_r  <= '0;
        second_r <= '0;
        node_r   <= '0;
        sum_r    <= '0;
      end else if (!sts.two_plus) begin
        kind_r   <= KIND_ROOT;
        first_r  <= '0;
        second_r <= '0;
        node_r   <= id_r[0];
        sum_r    <= cnt_r[0];
      end else begin
        kind_r   <= KIND_MERGE;
        first_r  <= id_r[0];
        second_r <= id_r[1];
        node_r   <= next_id_r;
        sum_r    <= sum_sat;
      end
    end
  end

  assign res_kind   = kind_r;
  assign res_first  = first_r;
  assign res_second = second_r;
  assign res_node   = node_r;
  assign res_count  = OUT_CNT_W'(sum_r);

  `HTB_ASSERT(a_total_bound, total_r <= TW'(SYMBOLS))
  `HTB_ASSERT(a_clear_empties, cmd.clr |=> total_r == '0)
  `HTB_ASSERT(a_pop_two, (cmd.eval && sts.two_plus) |=> total_r == $past(total_r) - TW'(2))
  `HTB_ASSERT(a_ins_after_pop, cmd.ins |-> $past(cmd.eval && sts.two_plus))
endmodule
`default_nettype wire

@@ sv/huffman_tree_builder_unit.sv @@
// ----------------------------------------------------------------------------
// Huffman tree builder unit
// Builds a Huffman tree step by step over a count-sorted entry list.
// ----------------------------------------------------------------------------
// Load and clear items give no result. A merge item steps through accept,
// read the two front entries and pop them, insert the summed node into the
// register list, and present the result, and the unit takes its next item
// once that result is taken. A merge that finds fewer than two entries has
// nothing to insert, so it skips the insert step. The list is a row of
// registers that inserts by parallel compare.
`default_nettype none
module huffman_tree_builder_unit #(
  parameter int SYMBOLS    = htb_pkg::SYMBOLS_DEF,
  parameter int COUNT_BITS = htb_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [htb_pkg::IN_DATA_W-1:0]   in_tdata,  // symbol[7:0], count[39:8]
  input  wire logic [1:0]                      in_tuser,  // action[1:0]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // first_child[8:0], second_child[17:9], node_id[26:18], node_count[58:27]
  output logic [htb_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [1:0]                           out_tuser  // kind[1:0]
);
  import htb_pkg::*;

  htb_cmd_t cmd;
  htb_sts_t sts;
  logic [1:0]           kind;
  logic [ID_W-1:0]      first_c, second_c, node;
  logic [OUT_CNT_W-1:0] ncount;

  htb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_action  (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  htb_dp #(
    .SYMBOLS    (SYMBOLS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_symbol  (in_tdata[7:0]),
    .in_count   (in_tdata[39:8]),
    .res_kind   (kind),
    .res_first  (first_c),
    .res_second (second_c),
    .res_node   (node),
    .res_count  (ncount)
  );

  assign out_tuser = kind;
  assign out_tdata = {5'b0, ncount, node, second_c, first_c};
endmodule
`default_nettype wire

@@ tb/sv/tb_huffman_tree_builder_unit.sv @@
// ----------------------------------------------------------------------------
// Huffman tree builder unit testbench
// Streams load, merge and clear items into the unit, including long random
// well-formed build sequences. It predicts every merge result with a
// count-sorted list model and checks every field of each result, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_huffman_tree_builder_unit;
  import htb_pkg::*;

  typedef struct {
    logic [1:0]  action;
    logic [7:0]  symbol;
    logic [31:0] count;
  } tree_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  first_child;
    logic [8:0]  second_child;
    logic [8:0]  node_id;
    logic [31:0] node_count;
  } tree_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  huffman_tree_builder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [8:0]  list_id[SYMBOLS_DEF];
  logic [31:0] list_cnt[SYMBOLS_DEF];
  int unsigned list_len = 0;
  logic [8:0]  next_node = ID_FIRST_INT;

  tree_item_t   pending_items[$];
  tree_result_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int merges_sent = 0;
  bit stim_done = 0;
  bit hold_off = 0;

  task automatic insert_entry(input logic [8:0] id, input logic [31:0] cnt);
    int pos;
    pos = 0;
    if (list_len >= SYMBOLS_DEF) return;
    while (pos < list_len && cnt > list_cnt[pos]) pos++;
    for (int k = list_len; k > pos; k--) begin
      list_id[k] = list_id[k-1];
      list_cnt[k] = list_cnt[k-1];
    end
    list_id[pos] = id;
    list_cnt[pos] = cnt;
    list_len++;
  endtask

  task automatic predict_tree_step(input tree_item_t it);
    tree_result_t r;
    logic [32:0] sum;
    r = '{KIND_EMPTY, 9'd0, 9'd0, 9'd0, 32'd0};
    case (it.action)
      ACT_LOAD: begin
        if (it.count != 0) insert_entry({1'b0, it.symbol}, it.count);
        return;
      end
      ACT_CLEAR: begin
        list_len = 0;
        next_node = ID_FIRST_INT;
        return;
      end
      ACT_MERGE: begin
        if (list_len == 1) begin
          r.kind = KIND_ROOT;
          r.node_id = list_id[0];
          r.node_count = list_cnt[0];
        end else if (list_len >= 2) begin
          sum = {1'b0, list_cnt[0]} + {1'b0, list_cnt[1]};
          r.kind = KIND_MERGE;
          r.first_child = list_id[0];
          r.second_child = list_id[1];
          r.node_id = next_node;
          r.node_count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          for (int k = 0; k + 2 < list_len; k++) begin
            list_id[k] = list_id[k+2];
            list_cnt[k] = list_cnt[k+2];
          end
          list_len -= 2;
          insert_entry(next_node, r.node_count);
          if (next_node < ID_LAST) next_node++;
        end
        expected_results.push_back(r);
      end
      default: return;
    endcase
  endtask

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_tree_step(pending_items.pop_front());
        send_gap = $urandom_range(0, 3);
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= {pending_items[0].count, pending_items[0].symbol};
          in_tuser <= pending_items[0].action;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    tree_result_t got, exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.first_child = out_tdata[8:0];
        got.second_child = out_tdata[17:9];
        got.node_id = out_tdata[26:18];
        got.node_count = out_tdata[58:27];
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result kind %0d", got.kind);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp k%0d %0d %0d %0d %0d got k%0d %0d %0d %0d %0d",
                       exp_r.kind, exp_r.first_child, exp_r.second_child,
                       exp_r.node_id, exp_r.node_count, got.kind, got.first_child,
                       got.second_child, got.node_id, got.node_count);
          end
        end
        recv_gap = $urandom_range(0, 3);
      end
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // long receiver stall while merges are flowing
  initial begin
    wait (rst_n);
    wait (results_seen >= 100);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic tree_item_t mk(input logic [1:0] a, input logic [7:0] s,
                                    input logic [31:0] c);
    tree_item_t t;
    t.action = a; t.symbol = s; t.count = c;
    return t;
  endfunction

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 4))
      0: return $urandom_range(1, 8);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  task automatic add(input tree_item_t t);
    pending_items.push_back(t);
    if (t.action == ACT_MERGE) merges_sent++;
  endtask

  initial begin
    int n, m, total;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed: empty merge, zero count, ties, saturation, root, clear, code 3
    add(mk(ACT_MERGE, 8'd0, 32'd0));
    add(mk(ACT_LOAD, 8'd5, 32'd0));
    add(mk(ACT_MERGE, 8'd0, 32'd0));
    add(mk(ACT_LOAD, 8'd0, 32'd7));
    add(mk(ACT_MERGE, 8'd0, 32'd0));
    add(mk(ACT_LOAD, 8'd255, 32'd7));
    add(mk(ACT_LOAD, 8'd1, 32'd7));
    add(mk(ACT_LOAD, 8'hAA, 32'hFFFF_FFFF));
    add(mk(ACT_LOAD, 8'h55, 32'hFFFF_FFFE));
    add(mk(2'd3, 8'hFF, 32'hFFFF_FFFF));
    for (int i = 0; i < 5; i++) add(mk(ACT_MERGE, 8'hFF, 32'hFFFF_FFFF));
    add(mk(ACT_CLEAR, 8'h12, 32'h1));
    add(mk(ACT_MERGE, 8'd0, 32'd0));
    // fill the list fully, load into the full list, then merge down to a single root
    for (int s = 0; s < 256; s++) add(mk(ACT_LOAD, s[7:0], $urandom_range(1, 50)));
    add(mk(ACT_LOAD, 8'd3, 32'd1));
    for (int i = 0; i < 256; i++) add(mk(ACT_MERGE, 8'd0, 32'd0));
    add(mk(ACT_CLEAR, 8'd0, 32'd0));
    // random: mostly well-formed builds, some noise
    total = 0;
    while (total < 220) begin
      if ($urandom_range(0, 4) == 0) begin
        add(mk($urandom_range(0, 3), $urandom, rand_count()));
        total++;
      end else begin
        n = $urandom_range(1, 12);
        m = n + $urandom_range(0, 2);
        add(mk(ACT_CLEAR, $urandom, $urandom));
        for (int i = 0; i < n; i++) add(mk(ACT_LOAD, $urandom, rand_count()));
        for (int i = 0; i < m; i++)
          add(mk(ACT_MERGE, $urandom, $urandom));
        total += 1 + n + m;
      end
    end
    wait (pending_items.size() == 0 && !in_tvalid);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    $display("Sent %0d merge items; checked %0d results against the sorted-list model.",
             merges_sent, results_seen);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("PASS huffman_tree_builder_unit");
    else
      $display("FAIL huffman_tree_builder_unit");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL huffman_tree_builder_unit");
    $finish;
  end
endmodule
`default_nettype wire
